// ===== sv/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg: shared types and codes of the bisection root search core
// widths, configuration register indexes, phase, result kind and command codes
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned TolWidth  = 31;
   localparam int unsigned IterWidth = 20;
   localparam int unsigned KindWidth = 2;

   localparam logic [TolWidth-1:0]  TolReset  = TolWidth'(17);
   localparam logic [IterWidth-1:0] IterReset = IterWidth'(1000000);

   typedef logic signed [DataWidth-1:0] value_type;
   typedef logic [KindWidth-1:0]        kind_type;
   typedef logic [1:0]                  phase_type;
   typedef logic                        csr_index_type;

   // configuration register indexes
   localparam csr_index_type CSR_TOLERANCE      = 1'b0;
   localparam csr_index_type CSR_MAX_ITERATIONS = 1'b1;

   // search phases
   localparam phase_type PH_IDLE   = 2'd0;
   localparam phase_type PH_WAIT_A = 2'd1;
   localparam phase_type PH_WAIT_B = 2'd2;
   localparam phase_type PH_WAIT_M = 2'd3;

   // result kinds
   localparam kind_type KIND_EVAL    = 2'd0;
   localparam kind_type KIND_ROOT    = 2'd1;
   localparam kind_type KIND_FAIL    = 2'd2;
   localparam kind_type KIND_IGNORED = 2'd3;

   // input commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_VALUE = 1'b1;

   typedef struct packed {
      kind_type  kind;
      value_type point;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/bisection_root_search_core.sv =====
// ----------------------------------------------------------------------------
// bisection_root_search_core: fixed point bisection root search engine
// searches a sign change of an external function in signed Q8.24
// ----------------------------------------------------------------------------
// Usage:
//  req channel: tuser carries the command (start or returned value), tdata the
//  interval ends and the function value. Every req transaction makes exactly
//  one rsp transaction: an evaluate request, a root, a failure, or a flag for
//  a value that arrived while no search was running.
//  The host evaluates f at every requested point and returns it on req.
//  A start transaction always restarts the search.
//  csr channel: index 0 tolerance, index 1 max_iterations; always ready, to be
//  written only while no search transaction is outstanding.
//  Output: each result is registered, in the skid register if the held result is not taken.
//  Throughput: one req transaction per cycle while req_tready is high; the search
//  state update is a single add, shift and compare pass between the state registers.
//  A two-entry output buffer (result register plus skid register) lets one
//  transaction be taken while a result waits; req_tready drops only when both
//  entries are full because the receiver stalls.
//  Reset: synchronous, clears the search to idle, empties the output buffer
//  and loads the register defaults (tolerance 17, max_iterations 1000000).
// ----------------------------------------------------------------------------
`default_nettype none

module bisection_root_search_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // left_end, right_end, function_value
   input  wire logic        req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // point
   output logic [1:0]       rsp_tuser,   // kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   logic [brs_pkg::TolWidth-1:0]  tolerance_ff;
   logic [brs_pkg::IterWidth-1:0] max_iter_ff;

   brs_pkg::phase_type  phase_ff, phase_in;
   brs_pkg::value_type  lower_end_ff, lower_end_in;
   brs_pkg::value_type  upper_end_ff, upper_end_in;
   brs_pkg::value_type  lower_value_ff, lower_value_in;
   brs_pkg::value_type  midpoint_ff, midpoint_in;
   logic [brs_pkg::IterWidth-1:0] iter_count_ff, iter_count_in;

   brs_pkg::result_type result_in;
   brs_pkg::result_type main_ff, skid_ff;
   logic                main_valid_ff, skid_valid_ff;

   logic push, pop;

   brs_pkg::value_type in_left, in_right, in_value;

   logic signed [32:0] lv_ext, v_ext, width_diff, mid_sum;
   logic [32:0]        lv_mag, v_mag, width_mag, tol_ext;
   logic               lv_small, v_small, width_small;
   logic               lv_pos, lv_neg, v_pos, v_neg;
   logic               budget_spent;
   brs_pkg::value_type mid_next;
   brs_pkg::value_type next_lower, next_upper;

   assign in_left  = req_tdata[31:0];
   assign in_right = req_tdata[63:32];
   assign in_value = req_tdata[95:64];

   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff.point;
   assign rsp_tuser  = main_ff.kind;

   // magnitude tests
   assign tol_ext     = {2'b00, tolerance_ff};
   assign lv_ext      = {lower_value_ff[31], lower_value_ff};
   assign v_ext       = {in_value[31], in_value};
   assign lv_mag      = lv_ext[32] ? 33'(-lv_ext) : 33'(lv_ext);
   assign v_mag       = v_ext[32] ? 33'(-v_ext) : 33'(v_ext);
   assign width_diff  = {upper_end_ff[31], upper_end_ff} - {lower_end_ff[31], lower_end_ff};
   assign width_mag   = width_diff[32] ? 33'(-width_diff) : 33'(width_diff);
   assign lv_small    = lv_mag < tol_ext;
   assign v_small     = v_mag < tol_ext;
   assign width_small = width_mag < tol_ext;

   assign lv_pos = !lower_value_ff[31] && (lower_value_ff != '0);
   assign lv_neg = lower_value_ff[31];
   assign v_pos  = !in_value[31] && (in_value != '0);
   assign v_neg  = in_value[31];

   assign budget_spent = iter_count_ff >= max_iter_ff;

   // midpoint of the interval after the side choice
   always_comb begin
      next_lower = lower_end_ff;
      next_upper = upper_end_ff;
      if (phase_ff == brs_pkg::PH_WAIT_M) begin
         if ((lv_pos && v_neg) || (lv_neg && v_pos)) begin
            next_upper = midpoint_ff;
         end else begin
            next_lower = midpoint_ff;
         end
      end
   end

   assign mid_sum  = {next_lower[31], next_lower} + {next_upper[31], next_upper};
   assign mid_next = mid_sum[32:1];

   always_comb begin
      phase_in       = phase_ff;
      lower_end_in   = lower_end_ff;
      upper_end_in   = upper_end_ff;
      lower_value_in = lower_value_ff;
      midpoint_in    = midpoint_ff;
      iter_count_in  = iter_count_ff;
      result_in.kind  = brs_pkg::KIND_IGNORED;
      result_in.point = '0;
      if (req_tuser == brs_pkg::CMD_START) begin
         lower_end_in    = in_left;
         upper_end_in    = in_right;
         lower_value_in  = '0;
         midpoint_in     = '0;
         iter_count_in   = '0;
         phase_in        = brs_pkg::PH_WAIT_A;
         result_in.kind  = brs_pkg::KIND_EVAL;
         result_in.point = in_left;
      end else begin
         case (phase_ff)
            brs_pkg::PH_WAIT_A: begin
               lower_value_in  = in_value;
               phase_in        = brs_pkg::PH_WAIT_B;
               result_in.kind  = brs_pkg::KIND_EVAL;
               result_in.point = upper_end_ff;
            end
            brs_pkg::PH_WAIT_B, brs_pkg::PH_WAIT_M: begin
               if (phase_ff == brs_pkg::PH_WAIT_B && lv_small) begin
                  phase_in        = brs_pkg::PH_IDLE;
                  result_in.kind  = brs_pkg::KIND_ROOT;
                  result_in.point = lower_end_ff;
               end else if (phase_ff == brs_pkg::PH_WAIT_B && v_small) begin
                  phase_in        = brs_pkg::PH_IDLE;
                  result_in.kind  = brs_pkg::KIND_ROOT;
                  result_in.point = upper_end_ff;
               end else if (phase_ff == brs_pkg::PH_WAIT_B &&
                            ((lv_pos && v_pos) || (lv_neg && v_neg))) begin
                  phase_in        = brs_pkg::PH_IDLE;
                  result_in.kind  = brs_pkg::KIND_FAIL;
               end else if (phase_ff == brs_pkg::PH_WAIT_M && (v_small || width_small)) begin
                  phase_in        = brs_pkg::PH_IDLE;
                  result_in.kind  = brs_pkg::KIND_ROOT;
                  result_in.point = midpoint_ff;
               end else begin
                  if (phase_ff == brs_pkg::PH_WAIT_M) begin
                     lower_end_in = next_lower;
                     upper_end_in = next_upper;
                     if (!((lv_pos && v_neg) || (lv_neg && v_pos))) begin
                        lower_value_in = in_value;
                     end
                  end
                  if (budget_spent) begin
                     phase_in        = brs_pkg::PH_IDLE;
                     result_in.kind  = brs_pkg::KIND_FAIL;
                  end else begin
                     midpoint_in     = mid_next;
                     iter_count_in   = iter_count_ff +
                                       {{(brs_pkg::IterWidth-1){1'b0}}, 1'b1};
                     phase_in        = brs_pkg::PH_WAIT_M;
                     result_in.kind  = brs_pkg::KIND_EVAL;
                     result_in.point = mid_next;
                  end
               end
            end
            default: begin
               result_in.kind  = brs_pkg::KIND_IGNORED;
               result_in.point = '0;
            end
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= brs_pkg::TolReset;
         max_iter_ff  <= brs_pkg::IterReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            brs_pkg::CSR_TOLERANCE:      tolerance_ff <= csr_data[brs_pkg::TolWidth-1:0];
            brs_pkg::CSR_MAX_ITERATIONS: max_iter_ff  <= csr_data[brs_pkg::IterWidth-1:0];
            default: begin
               tolerance_ff <= tolerance_ff;
            end
         endcase
      end
   end

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= brs_pkg::PH_IDLE;
         lower_end_ff   <= '0;
         upper_end_ff   <= '0;
         lower_value_ff <= '0;
         midpoint_ff    <= '0;
         iter_count_ff  <= '0;
      end else if (push) begin
         phase_ff       <= phase_in;
         lower_end_ff   <= lower_end_in;
         upper_end_ff   <= upper_end_in;
         lower_value_ff <= lower_value_in;
         midpoint_ff    <= midpoint_in;
         iter_count_ff  <= iter_count_in;
      end
   end

   // output buffer: result register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push && main_valid_ff && !pop) begin
         skid_valid_ff <= 1'b1;
      end else if (push) begin
         main_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push && main_valid_ff && !pop) begin
         skid_ff <= result_in;
      end else if (push) begin
         main_ff <= result_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_skid_needs_main : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while result register empty");

   a_accept_gives_result : assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("accepted transaction left no result");

   a_mid_wait_counted : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == brs_pkg::PH_WAIT_M) |-> (iter_count_ff != '0))
      else $error("midpoint wait with zero iteration count");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> (phase_ff == brs_pkg::PH_IDLE) && !rsp_tvalid)
      else $error("reset did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== tb/root_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// root_search_checker: result checker of the bisection root search core
// keeps its own copy of the search state and the tolerance and iteration
// limit registers, predicts one result for every accepted req transaction
// and compares each rsp transaction field by field with the oldest one
// ----------------------------------------------------------------------------

module root_search_checker
   import brs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [95:0]        req_tdata,   // left_end, right_end, function_value
   input  logic               req_tuser,   // command
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [31:0]        rsp_tdata,   // point
   input  logic [1:0]         rsp_tuser,   // kind
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_data,
   output int unsigned        fault_count,
   output int unsigned        outstanding,
   output result_type         last_result
);

   logic [TolWidth-1:0]  tol_q;
   logic [IterWidth-1:0] iter_limit_q;
   phase_type            phase_q;
   value_type            lower_q;
   value_type            upper_q;
   value_type            lower_val_q;
   value_type            mid_q;
   logic [IterWidth-1:0] iter_q;

   result_type  pending_results[$];
   result_type  seen;
   result_type  want;
   int unsigned faults;

   function automatic logic under_tol(input logic signed [63:0] v);
      logic signed [63:0] mag;
      mag = (v < 0) ? -v : v;
      return mag < $signed({33'd0, tol_q});
   endfunction

   // next midpoint probe, or give up once the iteration budget is spent
   function automatic result_type next_probe();
      result_type         r;
      logic signed [63:0] sum;
      if (iter_q >= iter_limit_q) begin
         phase_q = PH_IDLE;
         r.kind  = KIND_FAIL;
         r.point = '0;
      end else begin
         sum     = 64'(lower_q) + 64'(upper_q);
         mid_q   = value_type'(sum >>> 1);
         iter_q  = iter_q + {{(IterWidth-1){1'b0}}, 1'b1};
         phase_q = PH_WAIT_M;
         r.kind  = KIND_EVAL;
         r.point = mid_q;
      end
      return r;
   endfunction

   function automatic result_type bisect_step(input logic cmd, input value_type left,
                                              input value_type right, input value_type fv);
      result_type r;
      r.kind  = KIND_IGNORED;
      r.point = '0;
      if (cmd == CMD_START) begin
         lower_q     = left;
         upper_q     = right;
         lower_val_q = '0;
         mid_q       = '0;
         iter_q      = '0;
         phase_q     = PH_WAIT_A;
         r.kind      = KIND_EVAL;
         r.point     = left;
         return r;
      end
      case (phase_q)
         PH_WAIT_A: begin
            lower_val_q = fv;
            phase_q     = PH_WAIT_B;
            r.kind      = KIND_EVAL;
            r.point     = upper_q;
         end
         PH_WAIT_B: begin
            if (under_tol(64'(lower_val_q))) begin
               phase_q = PH_IDLE;
               r.kind  = KIND_ROOT;
               r.point = lower_q;
            end else if (under_tol(64'(fv))) begin
               phase_q = PH_IDLE;
               r.kind  = KIND_ROOT;
               r.point = upper_q;
            end else if ((lower_val_q > 0 && fv > 0) || (lower_val_q < 0 && fv < 0)) begin
               phase_q = PH_IDLE;
               r.kind  = KIND_FAIL;
            end else begin
               r = next_probe();
            end
         end
         PH_WAIT_M: begin
            if (under_tol(64'(fv)) || under_tol(64'(upper_q) - 64'(lower_q))) begin
               phase_q = PH_IDLE;
               r.kind  = KIND_ROOT;
               r.point = mid_q;
            end else begin
               if ((lower_val_q > 0 && fv < 0) || (lower_val_q < 0 && fv > 0)) begin
                  upper_q = mid_q;
               end else begin
                  lower_q     = mid_q;
                  lower_val_q = fv;
               end
               r = next_probe();
            end
         end
         default: begin
            r.kind  = KIND_IGNORED;
            r.point = '0;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tol_q        = TolReset;
         iter_limit_q = IterReset;
         phase_q      = PH_IDLE;
         lower_q      = '0;
         upper_q      = '0;
         lower_val_q  = '0;
         mid_q        = '0;
         iter_q       = '0;
         faults       = 0;
         pending_results.delete();
         fault_count  <= 0;
         outstanding  <= 0;
         last_result  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOLERANCE:      tol_q = csr_data[TolWidth-1:0];
               CSR_MAX_ITERATIONS: iter_limit_q = csr_data[IterWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.kind   = rsp_tuser;
            seen.point  = rsp_tdata;
            last_result <= seen;
            if (pending_results.size() == 0) begin
               if (faults < 10)
                  $display("%0t: unexpected rsp transaction kind %0d point %h",
                           $realtime, seen.kind, seen.point);
               faults++;
            end else begin
               want = pending_results.pop_front();
               if (want.kind !== seen.kind || want.point !== seen.point) begin
                  if (faults < 10)
                     $display("%0t: mismatch kind exp %0d got %0d, point exp %h got %h",
                              $realtime, want.kind, seen.kind, want.point, seen.point);
                  faults++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(bisect_step(req_tuser, req_tdata[31:0],
                                                  req_tdata[63:32], req_tdata[95:64]));
         outstanding <= pending_results.size();
         fault_count <= faults;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: bisection root search core
// drives start and function value transactions, acting as the host that
// evaluates a random linear function at every requested point, with noise
// bursts, abandoned searches and register settings from zero to full scale;
// both channels stall at random, the checker judges every rsp transaction
// ----------------------------------------------------------------------------

module testbench;
   import brs_pkg::*;

   localparam int QuietLimit = 2000;
   localparam int RandomItems = 450;
   localparam int SteadyFrom = 170;
   localparam int SteadyTo = 280;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   int unsigned fault_count;
   int unsigned outstanding;
   result_type  last_result;
   int          sent = 0;
   int          quiet_cycles = 0;
   logic        steady = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bisection_root_search_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   root_search_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fault_count (fault_count),
      .outstanding (outstanding),
      .last_result (last_result)
   );

   always @(negedge clock) begin
      if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge; leaves tvalid high after the transaction
   task automatic send_req(input logic cmd, input value_type left, input value_type right,
                           input value_type fval);
      steady = (sent >= SteadyFrom && sent < SteadyTo);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {fval, right, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_config(input logic [31:0] tol_word, input logic [31:0] iter_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_TOLERANCE;
      csr_data  <= tol_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_MAX_ITERATIONS;
      csr_data  <= iter_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      value_type          left;
      value_type          right;
      value_type          fval;
      value_type          root_x;
      logic signed [63:0] gain;
      logic signed [63:0] offset;
      logic signed [63:0] fy;
      logic [30:0]        tol;
      logic [19:0]        iter;
      int                 steps;
      int                 cap;
      int                 target;
      int                 next_cfg;
      int                 cfg_round;
      int                 burst;
      int                 lo_i;
      int                 span;
      int                 pick;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // values while idle, root at either end, same signs, reversed interval,
      // restart while busy, extremes of every field
      send_req(CMD_VALUE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_req(CMD_VALUE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_req(CMD_START, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_req(CMD_VALUE, 0, 0, 0);
      send_req(CMD_VALUE, 0, 0, 100);
      send_req(CMD_START, 32'h0100_0000, 32'h0200_0000, 0);
      send_req(CMD_VALUE, 0, 0, -1000);
      send_req(CMD_VALUE, 0, 0, 5);
      send_req(CMD_START, 10, -10, 0);
      send_req(CMD_VALUE, 0, 0, 1000);
      send_req(CMD_VALUE, 0, 0, 2000);
      send_req(CMD_START, -100000, 100000, 0);
      send_req(CMD_VALUE, 0, 0, 32'h8000_0000);
      send_req(CMD_VALUE, 0, 0, 32'h7FFF_FFFF);
      send_req(CMD_VALUE, 0, 0, -500);
      send_req(CMD_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_req(CMD_VALUE, 0, 0, -1000);
      send_req(CMD_VALUE, 0, 0, -2000);
      send_req(CMD_VALUE, 0, 0, 3);
      wait_drained();
      // zero tolerance, no midpoint allowed
      write_config(32'd0, 32'd0);
      send_req(CMD_START, -1000, 1000, 0);
      send_req(CMD_VALUE, 0, 0, -5);
      send_req(CMD_VALUE, 0, 0, 5);
      wait_drained();
      // largest tolerance and iteration limit, junk in the unused data bits
      write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(CMD_START, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_req(CMD_VALUE, 0, 0, 32'h8000_0000);
      send_req(CMD_VALUE, 0, 0, 32'h7FFF_FFFF);
      send_req(CMD_VALUE, 0, 0, 0);

      target    = sent + RandomItems;
      next_cfg  = sent;
      cfg_round = 0;
      while (sent < target) begin
         if (sent >= next_cfg) begin
            wait_drained();
            case (cfg_round % 6)
               0:       tol = '0;
               1:       tol = 31'd1;
               2:       tol = 31'd17;
               3:       tol = '1;
               4:       tol = 31'($urandom_range(0, 4096));
               default: tol = 31'($urandom);
            endcase
            case (cfg_round % 5)
               0:       iter = '1;
               1:       iter = 20'd1;
               2:       iter = 20'($urandom_range(2, 40));
               3:       iter = '0;
               default: iter = 20'($urandom);
            endcase
            write_config({1'($urandom), tol}, {12'($urandom), iter});
            cfg_round++;
            next_cfg = sent + 60;
         end
         if ($urandom_range(0, 99) < 80) begin
            // one search against a random linear function
            if ($urandom_range(0, 9) < 2) begin
               left   = $urandom;
               right  = $urandom;
               root_x = $urandom;
            end else begin
               lo_i   = int'($urandom_range(0, 1 << 26)) - (1 << 25);
               span   = int'($urandom_range(1, 1 << $urandom_range(0, 24)));
               root_x = lo_i + int'($urandom_range(0, span));
               if ($urandom_range(0, 9) == 0) begin
                  left  = lo_i + span;
                  right = lo_i;
               end else begin
                  left  = lo_i;
                  right = lo_i + span;
               end
               if ($urandom_range(0, 4) == 0) root_x = $urandom;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) gain = 64'sd0;
            else if (pick < 12) gain = 64'sd1 <<< $urandom_range(0, 12);
            else gain = 64'($urandom_range(1, 5000));
            if ($urandom_range(0, 1)) gain = -gain;
            if ($urandom_range(0, 6) == 0)
               offset = 64'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            else offset = 64'sd0;

            send_req(CMD_START, left, right, $urandom);
            wait_drained();
            cap   = $urandom_range(1, 60);
            steps = 0;
            while (last_result.kind == KIND_EVAL && steps < cap) begin
               if ($urandom_range(0, 99) < 5) begin
                  fval = $urandom;
               end else begin
                  fy = (64'(last_result.point) - 64'(root_x)) * gain + offset;
                  if (fy > 64'sd2147483647) fval = 32'h7FFF_FFFF;
                  else if (fy < -64'sd2147483648) fval = 32'h8000_0000;
                  else fval = fy[31:0];
               end
               send_req(CMD_VALUE, $urandom, $urandom, fval);
               wait_drained();
               steps++;
            end
         end else begin
            // back to back noise
            burst = $urandom_range(1, 8);
            repeat (burst) send_req(1'($urandom), $urandom, $urandom, $urandom);
            wait_drained();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
